### hw/rtl/qsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsv_pkg
// Shared types, operation codes and the product schedule of the gate engine.
// ----------------------------------------------------------------------------
package qsv_pkg;

  localparam int HALF_ROOT2 = 23170;

  typedef enum logic [3:0] {
    OP_INIT    = 4'd0,
    OP_H       = 4'd1,
    OP_X       = 4'd2,
    OP_Y       = 4'd3,
    OP_Z       = 4'd4,
    OP_CNOT    = 4'd5,
    OP_TOFFOLI = 4'd6,
    OP_RX      = 4'd7,
    OP_RY      = 4'd8,
    OP_RZ      = 4'd9,
    OP_CPHASE  = 4'd10,
    OP_ORACLE  = 4'd11,
    OP_DIFFUSE = 4'd12,
    OP_MEASURE = 4'd13,
    OP_READ    = 4'd14
  } op_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_P_RX, S_P_RY, S_P_LY, S_P_MAC, S_P_W0, S_P_W1, S_P_NEXT,
    S_D_SUM, S_D_SUMF, S_D_AVG, S_D_WR, S_D_WRF,
    S_M_RD, S_M_SQA, S_M_SQB, S_M_ADD, S_M_TGT,
    S_R_RD, S_R_LD, S_OUT
  } state_t;

  typedef enum logic [1:0] {SRC_XR, SRC_XI, SRC_YR, SRC_YI} src_t;

  typedef enum logic [2:0] {
    K_ZERO, K_C, K_S, K_NS, K_H, K_NH, K_ONE, K_MONE
  } coef_t;

  typedef struct packed {
    src_t  src;
    coef_t coef;
  } mac_sel_t;

  localparam mac_sel_t NO_TERM = '{SRC_XR, K_ZERO};

  // Two products per output: outputs re0, im0, re1, im1 in that order.
  function automatic mac_sel_t mac_sel(input op_t code, input logic [2:0] step);
    mac_sel_t tab [8];
    case (code)
      OP_H: tab = '{'{SRC_XR, K_H}, '{SRC_YR, K_H}, '{SRC_XI, K_H}, '{SRC_YI, K_H},
                    '{SRC_XR, K_H}, '{SRC_YR, K_NH}, '{SRC_XI, K_H}, '{SRC_YI, K_NH}};
      OP_X, OP_CNOT, OP_TOFFOLI:
        tab = '{'{SRC_YR, K_ONE}, NO_TERM, '{SRC_YI, K_ONE}, NO_TERM,
                '{SRC_XR, K_ONE}, NO_TERM, '{SRC_XI, K_ONE}, NO_TERM};
      OP_Y: tab = '{'{SRC_YI, K_ONE}, NO_TERM, '{SRC_YR, K_MONE}, NO_TERM,
                    '{SRC_XI, K_MONE}, NO_TERM, '{SRC_XR, K_ONE}, NO_TERM};
      OP_Z: tab = '{'{SRC_XR, K_ONE}, NO_TERM, '{SRC_XI, K_ONE}, NO_TERM,
                    '{SRC_YR, K_MONE}, NO_TERM, '{SRC_YI, K_MONE}, NO_TERM};
      OP_RX: tab = '{'{SRC_XR, K_C}, '{SRC_YI, K_S}, '{SRC_XI, K_C}, '{SRC_YR, K_NS},
                     '{SRC_XI, K_S}, '{SRC_YR, K_C}, '{SRC_YI, K_C}, '{SRC_XR, K_NS}};
      OP_RY: tab = '{'{SRC_XR, K_C}, '{SRC_YR, K_NS}, '{SRC_XI, K_C}, '{SRC_YI, K_NS},
                     '{SRC_XR, K_S}, '{SRC_YR, K_C}, '{SRC_XI, K_S}, '{SRC_YI, K_C}};
      OP_RZ: tab = '{'{SRC_XR, K_C}, '{SRC_XI, K_S}, '{SRC_XI, K_C}, '{SRC_XR, K_NS},
                     '{SRC_YR, K_C}, '{SRC_YI, K_NS}, '{SRC_YI, K_C}, '{SRC_YR, K_S}};
      OP_CPHASE:
        tab = '{'{SRC_XR, K_ONE}, NO_TERM, '{SRC_XI, K_ONE}, NO_TERM,
                '{SRC_YR, K_C}, '{SRC_YI, K_NS}, '{SRC_YR, K_S}, '{SRC_YI, K_C}};
      OP_ORACLE:
        tab = '{'{SRC_XR, K_MONE}, NO_TERM, '{SRC_XI, K_MONE}, NO_TERM,
                NO_TERM, NO_TERM, NO_TERM, NO_TERM};
      default: tab = '{default: NO_TERM};
    endcase
    return tab[step];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/qsv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsv_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module qsv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/qsv_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsv_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module qsv_mul #(
  parameter int A_BITS = 17,
  parameter int B_BITS = 18
) (
  input  wire logic                            clk,
  input  wire logic signed [A_BITS-1:0]        a,
  input  wire logic signed [B_BITS-1:0]        b,
  output logic      signed [A_BITS+B_BITS-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

### hw/rtl/qubit_state_vector_gate_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qubit_state_vector_gate_engine_core
// State vector gate engine: one RAM of amplitudes, one shared multiplier.
// ----------------------------------------------------------------------------
// Sequencing: pair gates step over 2^(n-1) amplitude pairs and skip a pair that
//   the control mask leaves out; measure may stop at the first hit; init clears
//   all 2^MAX_QUBITS entries; every result then goes through the output register.
// Throughput: one operation at a time, set by the single RAM port and the
//   multiplier shared by all products.
// Reset and any qubit_count write run a clearing pass over all 2^MAX_QUBITS entries.
module qubit_state_vector_gate_engine_core import qsv_pkg::*; #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [3:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         op,
  input  wire logic [3:0]         target_qubit,
  input  wire logic [3:0]         first_control,
  input  wire logic [3:0]         second_control,
  input  wire logic signed [15:0] angle_cos,
  input  wire logic signed [15:0] angle_sin,
  input  wire logic [9:0]         state_index,
  input  wire logic [15:0]        random_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [9:0]              measured_state,
  output logic signed [15:0]      amp_real,
  output logic signed [15:0]      amp_imag,
  output logic                    bad_qubit
);

  localparam int AW    = MAX_QUBITS;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = $clog2(MAX_QUBITS + 1);
  localparam int MA    = (AMP_BITS > 17) ? AMP_BITS : 17;
  localparam int PW    = MA + 18;
  localparam int SW    = AMP_BITS + MAX_QUBITS + 2;
  localparam int TW    = 33 + MAX_QUBITS;
  localparam int NCH   = (TW + 15) / 16;
  localparam int TPAD  = NCH * 16;
  localparam int CW    = $clog2(NCH + 1);

  localparam logic signed [AMP_BITS-1:0] AMAX = {1'b0, {(AMP_BITS-1){1'b1}}};
  localparam logic signed [AMP_BITS-1:0] AMIN = {1'b1, {(AMP_BITS-1){1'b0}}};
  localparam logic signed [PW:0]         RND_HALF = 16384;

  function automatic logic signed [AMP_BITS-1:0] rsat(input logic signed [PW:0] v);
    logic signed [PW:0] r;
    r = (v + RND_HALF) >>> 15;
    if (r > (PW+1)'(AMAX)) return AMAX;
    if (r < (PW+1)'(AMIN)) return AMIN;
    return r[AMP_BITS-1:0];
  endfunction

  function automatic logic signed [AMP_BITS-1:0] dsat(input logic signed [SW:0] v);
    if (v > (SW+1)'(AMAX)) return AMAX;
    if (v < (SW+1)'(AMIN)) return AMIN;
    return v[AMP_BITS-1:0];
  endfunction

  function automatic logic signed [15:0] q15(input logic signed [AMP_BITS-1:0] v);
    logic signed [AMP_BITS+15:0] w;
    w = {v, 16'b0};
    w = w >>> AMP_BITS;
    return w[15:0];
  endfunction

  state_t state, state_next;

  logic [3:0]    qubit_count;
  logic [NW-1:0] n_act;
  logic [AW-1:0] sz_mask, last_k;

  op_t                  op_in, op_r;
  logic                 bad_in, idx_ok_in;
  logic [AW-1:0]        tm_in, cm_in;
  logic signed [17:0]   cx, sx;
  logic [9:0]           idx_r;
  logic [15:0]          rnd_r;
  logic [AW-1:0]        tm, cm, k, ptr, rptr;
  logic                 single, clr_op, rv, mpass;
  logic [3:0]           step;
  logic [2:0]           stp;
  logic [CW-1:0]        chs;

  logic signed [AMP_BITS-1:0] x_re, x_im, y_re, y_im, rd_re, rd_im;
  logic signed [AMP_BITS-1:0] nres [4];
  logic signed [PW-1:0]       acc, prod;
  logic signed [SW-1:0]       sr, si, avg_re, avg_im, t_re, t_im;
  logic [SW-1:0]              half_u;
  logic [31:0]                sq;
  logic [32:0]                e;
  logic [TPAD-1:0]            total, cum, cum_next;
  logic [TPAD+15:0]           target;
  logic                       hit;

  logic [9:0]         res_meas;
  logic signed [15:0] res_re, res_im;
  logic               res_bad;

  logic [AW-1:0]   low, i0, i1;
  logic            cond;
  mac_sel_t        sel;
  logic signed [AMP_BITS-1:0] srcv;
  logic signed [MA-1:0]       mul_a;
  logic signed [17:0]         mul_b;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [2*AMP_BITS-1:0]   ram_wdata, ram_rdata;

  qsv_ram #(.WIDTH(2 * AMP_BITS), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  qsv_mul #(.A_BITS(MA), .B_BITS(18)) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  assign rd_re = ram_rdata[2*AMP_BITS-1:AMP_BITS];
  assign rd_im = ram_rdata[AMP_BITS-1:0];

  always_comb begin
    if (qubit_count == 4'd0) begin
      n_act = NW'(1);
    end else if (int'(qubit_count) > MAX_QUBITS) begin
      n_act = NW'(MAX_QUBITS);
    end else begin
      n_act = NW'(qubit_count);
    end
  end

  assign sz_mask = ~({AW{1'b1}} << n_act);
  assign last_k  = sz_mask >> 1;

  // Input decode
  always_comb begin
    op_in  = op_t'(op);
    bad_in = 1'b0;
    if (op_in >= OP_H && op_in <= OP_CPHASE && int'(target_qubit) >= int'(n_act)) begin
      bad_in = 1'b1;
    end
    if ((op_in == OP_CNOT || op_in == OP_TOFFOLI || op_in == OP_CPHASE) &&
        int'(first_control) >= int'(n_act)) begin
      bad_in = 1'b1;
    end
    if (op_in == OP_TOFFOLI && int'(second_control) >= int'(n_act)) begin
      bad_in = 1'b1;
    end
    tm_in = AW'(1) << target_qubit;
    cm_in = '0;
    if (op_in == OP_CNOT || op_in == OP_TOFFOLI || op_in == OP_CPHASE) begin
      cm_in = AW'(1) << first_control;
    end
    if (op_in == OP_TOFFOLI) begin
      cm_in = cm_in | (AW'(1) << second_control);
    end
    idx_ok_in = (state_index >> n_act) == 10'd0;
  end

  // Pair addressing
  always_comb begin
    low  = tm - AW'(1);
    i0   = single ? AW'(idx_r) : (((k & ~low) << 1) | (k & low));
    i1   = i0 | tm;
    cond = single || ((i1 & cm) == cm);
  end

  // Measurement and diffusion arithmetic
  always_comb begin
    stp      = 3'(step - 4'd1);
    e        = {1'b0, sq} + {1'b0, prod[31:0]};
    cum_next = cum + TPAD'(e);
    hit      = target <= {cum_next, 16'b0};
    half_u   = SW'(sz_mask >> 1) + SW'(1);
    t_re     = (sr <<< 1) + $signed(half_u);
    t_im     = (si <<< 1) + $signed(half_u);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR: if (ptr == {AW{1'b1}}) begin
        state_next = clr_op ? S_OUT : S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        if (bad_in) begin
          state_next = S_OUT;
        end else begin
          case (op_in)
            OP_INIT: state_next = S_CLR;
            OP_H, OP_X, OP_Y, OP_Z, OP_CNOT, OP_TOFFOLI,
            OP_RX, OP_RY, OP_RZ, OP_CPHASE: state_next = S_P_RX;
            OP_ORACLE:  state_next = idx_ok_in ? S_P_RX : S_OUT;
            OP_DIFFUSE: state_next = S_D_SUM;
            OP_MEASURE: state_next = S_M_RD;
            OP_READ:    state_next = idx_ok_in ? S_R_RD : S_OUT;
            default:    state_next = S_OUT;
          endcase
        end
      end
      S_P_RX:   state_next = cond ? S_P_RY : S_P_NEXT;
      S_P_RY:   state_next = S_P_LY;
      S_P_LY:   state_next = S_P_MAC;
      S_P_MAC:  if (step == 4'd8) state_next = S_P_W0;
      S_P_W0:   state_next = single ? S_OUT : S_P_W1;
      S_P_W1:   state_next = S_P_NEXT;
      S_P_NEXT: state_next = (k == last_k) ? S_OUT : S_P_RX;
      S_D_SUM:  if (ptr == sz_mask) state_next = S_D_SUMF;
      S_D_SUMF: state_next = S_D_AVG;
      S_D_AVG:  state_next = S_D_WR;
      S_D_WR:   if (ptr == sz_mask) state_next = S_D_WRF;
      S_D_WRF:  state_next = S_OUT;
      S_M_RD:   state_next = S_M_SQA;
      S_M_SQA:  state_next = S_M_SQB;
      S_M_SQB:  state_next = S_M_ADD;
      S_M_ADD: begin
        if (mpass && hit) begin
          state_next = S_OUT;
        end else if (ptr == sz_mask) begin
          state_next = mpass ? S_OUT : S_M_TGT;
        end else begin
          state_next = S_M_RD;
        end
      end
      S_M_TGT:  if (int'(chs) == NCH) state_next = S_M_RD;
      S_R_RD:   state_next = S_R_LD;
      S_R_LD:   state_next = S_OUT;
      S_OUT:    if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
    if (cfg_write) begin
      state_next = S_CLR;
    end
  end

  // Control outputs
  always_comb begin
    in_ready  = state == S_IDLE;
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = '0;
    ram_raddr = ptr;
    mul_a     = '0;
    mul_b     = '0;
    sel       = mac_sel(op_r, step[2:0]);
    case (sel.src)
      SRC_XR:  srcv = x_re;
      SRC_XI:  srcv = x_im;
      SRC_YR:  srcv = y_re;
      SRC_YI:  srcv = y_im;
      default: srcv = x_re;
    endcase
    case (state)
      S_CLR: begin
        ram_we = 1'b1;
        if (ptr == '0) ram_wdata = {AMAX, {AMP_BITS{1'b0}}};
      end
      S_P_RX: ram_raddr = i0;
      S_P_RY: ram_raddr = i1;
      S_P_MAC: if (step < 4'd8) begin
        mul_a = MA'(srcv);
        case (sel.coef)
          K_C:     mul_b = cx;
          K_S:     mul_b = sx;
          K_NS:    mul_b = -sx;
          K_H:     mul_b = 18'sd23170;
          K_NH:    mul_b = -18'sd23170;
          K_ONE:   mul_b = 18'sd32768;
          K_MONE:  mul_b = -18'sd32768;
          default: mul_b = '0;
        endcase
      end
      S_P_W0: begin
        ram_we    = 1'b1;
        ram_waddr = i0;
        ram_wdata = {nres[0], nres[1]};
      end
      S_P_W1: begin
        ram_we    = 1'b1;
        ram_waddr = i1;
        ram_wdata = {nres[2], nres[3]};
      end
      S_D_WR, S_D_WRF: begin
        ram_we    = rv;
        ram_waddr = rptr;
        ram_wdata = {dsat((SW+1)'(avg_re) - (SW+1)'(rd_re)),
                     dsat((SW+1)'(avg_im) - (SW+1)'(rd_im))};
      end
      S_M_SQA: begin
        mul_a = MA'(q15(rd_re));
        mul_b = 18'(q15(rd_re));
      end
      S_M_SQB: begin
        mul_a = MA'(q15(rd_im));
        mul_b = 18'(q15(rd_im));
      end
      S_M_TGT: if (int'(chs) < NCH) begin
        mul_a = $signed(MA'({1'b0, total[16*chs +: 16]}));
        mul_b = $signed({2'b00, rnd_r});
      end
      S_R_RD: ram_raddr = AW'(idx_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      qubit_count <= 4'd8;
      ptr         <= '0;
      clr_op      <= 1'b0;
      out_valid   <= 1'b0;
      rv          <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: ptr <= ptr + AW'(1);
        S_IDLE: if (in_valid) begin
          op_r     <= op_in;
          cx       <= 18'(angle_cos);
          sx       <= 18'(angle_sin);
          idx_r    <= state_index;
          rnd_r    <= random_value;
          tm       <= tm_in;
          cm       <= cm_in;
          single   <= op_in == OP_ORACLE;
          res_meas <= '0;
          res_re   <= '0;
          res_im   <= '0;
          res_bad  <= bad_in;
          ptr      <= '0;
          k        <= '0;
          rv       <= 1'b0;
          sr       <= '0;
          si       <= '0;
          total    <= '0;
          cum      <= '0;
          target   <= '0;
          mpass    <= 1'b0;
          chs      <= '0;
          clr_op   <= 1'b1;
        end
        S_P_RY: begin
          x_re <= rd_re;
          x_im <= rd_im;
        end
        S_P_LY: begin
          y_re <= rd_re;
          y_im <= rd_im;
          step <= '0;
        end
        S_P_MAC: begin
          step <= step + 4'd1;
          if (step != 4'd0) begin
            if (!stp[0]) begin
              acc <= prod;
            end else begin
              nres[stp[2:1]] <= rsat((PW+1)'(acc) + (PW+1)'(prod));
            end
          end
        end
        S_P_NEXT: k <= k + AW'(1);
        S_D_SUM: begin
          rv   <= 1'b1;
          rptr <= ptr;
          ptr  <= ptr + AW'(1);
          if (rv) begin
            sr <= sr + SW'(rd_re);
            si <= si + SW'(rd_im);
          end
        end
        S_D_SUMF: begin
          rv <= 1'b0;
          sr <= sr + SW'(rd_re);
          si <= si + SW'(rd_im);
        end
        S_D_AVG: begin
          avg_re <= t_re >>> n_act;
          avg_im <= t_im >>> n_act;
          ptr    <= '0;
        end
        S_D_WR: begin
          rv   <= 1'b1;
          rptr <= ptr;
          ptr  <= ptr + AW'(1);
        end
        S_D_WRF: rv <= 1'b0;
        S_M_SQB: sq <= prod[31:0];
        S_M_ADD: begin
          if (!mpass) begin
            total <= total + TPAD'(e);
          end else begin
            cum <= cum_next;
          end
          if ((mpass && hit) || (mpass && ptr == sz_mask)) begin
            res_meas <= 10'(ptr);
          end else if (ptr == sz_mask) begin
            ptr <= '0;
            chs <= '0;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_M_TGT: begin
          chs <= chs + CW'(1);
          if (chs != '0) begin
            target <= target + ((TPAD+16)'(prod[31:0]) << (16 * (chs - CW'(1))));
          end
          if (int'(chs) == NCH) begin
            mpass <= 1'b1;
            ptr   <= '0;
            cum   <= '0;
          end
        end
        S_R_LD: begin
          res_re <= q15(rd_re);
          res_im <= q15(rd_im);
        end
        S_OUT: if (!out_valid || out_ready) begin
          out_valid      <= 1'b1;
          measured_state <= res_meas;
          amp_real       <= res_re;
          amp_imag       <= res_im;
          bad_qubit      <= res_bad;
        end
        default: ;
      endcase
      if (cfg_write) begin
        qubit_count <= cfg_data;
        ptr         <= '0;
        clr_op      <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we) else $error("RAM write while idle");
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we && state != S_CLR |-> (ram_waddr & ~sz_mask) == '0)
    else $error("write beyond active state size");
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT) else $error("result without sequencer");
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> state == S_CLR && ptr == '0) else $error("config write did not clear");
  a_mac_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_P_MAC |-> step <= 4'd8) else $error("product step overrun");
`endif

endmodule
`default_nettype wire

### tb/qubit_state_vector_gate_engine_core_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qubit_state_vector_gate_engine_core_chk
// Watches the operation and result channels and the qubit_count port, keeps
// its own amplitude vector, predicts the result of every accepted operation
// and compares each result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module qubit_state_vector_gate_engine_core_chk import qsv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         op,
  input  logic [3:0]         target_qubit,
  input  logic [3:0]         first_control,
  input  logic [3:0]         second_control,
  input  logic signed [15:0] angle_cos,
  input  logic signed [15:0] angle_sin,
  input  logic [9:0]         state_index,
  input  logic [15:0]        random_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [9:0]         measured_state,
  input  logic signed [15:0] amp_real,
  input  logic signed [15:0] amp_imag,
  input  logic               bad_qubit,
  output int                 fail_count,
  output int                 pending
);

  localparam longint AMAX = 32767;
  localparam longint AMIN = -32768;

  typedef struct {
    logic [9:0]         meas;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               bad;
  } gate_result_t;

  gate_result_t result_q[$];
  longint vec_re[1024];
  longint vec_im[1024];
  longint tmp_re[1024];
  longint tmp_im[1024];
  logic [3:0] qubits_reg;

  assign pending = result_q.size();

  function automatic longint sat(longint x);
    if (x > AMAX) return AMAX;
    if (x < AMIN) return AMIN;
    return x;
  endfunction

  function automatic longint rnd15(longint x);
    return sat((x + 16384) >>> 15);
  endfunction

  function automatic int active_n();
    if (qubits_reg < 1) return 1;
    if (qubits_reg > 10) return 10;
    return qubits_reg;
  endfunction

  task automatic clear_vector();
    for (int k = 0; k < 1024; k++) begin
      vec_re[k] = 0;
      vec_im[k] = 0;
    end
    vec_re[0] = AMAX;
  endtask

  task automatic swap_pairs(int size, int cm, int tm);
    int j;
    tmp_re = vec_re;
    tmp_im = vec_im;
    for (int k = 0; k < size; k++) begin
      if ((k & cm) == cm) begin
        j = k ^ tm;
        tmp_re[j] = vec_re[k]; tmp_im[j] = vec_im[k];
        tmp_re[k] = vec_re[j]; tmp_im[k] = vec_im[j];
      end
    end
    vec_re = tmp_re;
    vec_im = tmp_im;
  endtask

  task automatic apply_gate(output gate_result_t res);
    op_t code;
    int n, size, tm, cm, j;
    longint c, s, xr, xi, yr, yi, n0r, n0i, n1r, n1i, sr, si, ar, ai;
    longint total, cum, p;
    longint rv;
    code = op_t'(op);
    n = active_n();
    size = 1 << n;
    tm = 0;
    cm = 0;
    c = angle_cos;
    s = angle_sin;
    rv = random_value;
    res.meas = 0;
    res.re = 0;
    res.im = 0;
    res.bad = 0;
    if (op >= OP_H && op <= OP_CPHASE && target_qubit >= n) res.bad = 1;
    if ((code == OP_CNOT || code == OP_TOFFOLI || code == OP_CPHASE) && first_control >= n)
      res.bad = 1;
    if (code == OP_TOFFOLI && second_control >= n) res.bad = 1;
    if (res.bad) return;
    tm = 1 << target_qubit;
    cm = 1 << first_control;
    if (code == OP_TOFFOLI) cm |= 1 << second_control;
    case (code)
      OP_INIT: clear_vector();
      OP_H, OP_Y, OP_RX, OP_RY, OP_RZ: begin
        for (int k = 0; k < size; k++) begin
          if ((k & tm) == 0) begin
            j = k | tm;
            xr = vec_re[k]; xi = vec_im[k]; yr = vec_re[j]; yi = vec_im[j];
            case (code)
              OP_H: begin
                n0r = rnd15((xr + yr) * HALF_ROOT2); n0i = rnd15((xi + yi) * HALF_ROOT2);
                n1r = rnd15((xr - yr) * HALF_ROOT2); n1i = rnd15((xi - yi) * HALF_ROOT2);
              end
              OP_Y: begin
                n0r = yi; n0i = sat(-yr);
                n1r = sat(-xi); n1i = xr;
              end
              OP_RX: begin
                n0r = rnd15(xr * c + yi * s); n0i = rnd15(xi * c - yr * s);
                n1r = rnd15(xi * s + yr * c); n1i = rnd15(yi * c - xr * s);
              end
              OP_RY: begin
                n0r = rnd15(xr * c - yr * s); n0i = rnd15(xi * c - yi * s);
                n1r = rnd15(xr * s + yr * c); n1i = rnd15(xi * s + yi * c);
              end
              default: begin
                n0r = rnd15(xr * c + xi * s); n0i = rnd15(xi * c - xr * s);
                n1r = rnd15(yr * c - yi * s); n1i = rnd15(yi * c + yr * s);
              end
            endcase
            vec_re[k] = n0r; vec_im[k] = n0i;
            vec_re[j] = n1r; vec_im[j] = n1i;
          end
        end
      end
      OP_X: swap_pairs(size, 0, tm);
      OP_Z: begin
        for (int k = 0; k < size; k++)
          if (k & tm) begin
            vec_re[k] = sat(-vec_re[k]);
            vec_im[k] = sat(-vec_im[k]);
          end
      end
      OP_CNOT, OP_TOFFOLI: swap_pairs(size, cm, tm);
      OP_CPHASE: begin
        for (int k = 0; k < size; k++)
          if ((k & cm) && (k & tm)) begin
            xr = vec_re[k]; xi = vec_im[k];
            vec_re[k] = rnd15(xr * c - xi * s);
            vec_im[k] = rnd15(xr * s + xi * c);
          end
      end
      OP_ORACLE: begin
        if (state_index < size) begin
          vec_re[state_index] = sat(-vec_re[state_index]);
          vec_im[state_index] = sat(-vec_im[state_index]);
        end
      end
      OP_DIFFUSE: begin
        sr = 0;
        si = 0;
        for (int k = 0; k < size; k++) begin
          sr += vec_re[k];
          si += vec_im[k];
        end
        ar = (2 * sr + (size >> 1)) >>> n;
        ai = (2 * si + (size >> 1)) >>> n;
        for (int k = 0; k < size; k++) begin
          vec_re[k] = sat(ar - vec_re[k]);
          vec_im[k] = sat(ai - vec_im[k]);
        end
      end
      OP_MEASURE: begin
        total = 0;
        cum = 0;
        for (int k = 0; k < size; k++)
          total += vec_re[k] * vec_re[k] + vec_im[k] * vec_im[k];
        for (int k = 0; k < size; k++) begin
          p = vec_re[k] * vec_re[k] + vec_im[k] * vec_im[k];
          cum += p;
          if (rv * total <= cum * 65536) begin
            res.meas = 10'(k);
            break;
          end
        end
      end
      OP_READ: begin
        if (state_index < size) begin
          res.re = 16'(vec_re[state_index]);
          res.im = 16'(vec_im[state_index]);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    gate_result_t exp_r;
    gate_result_t got;
    if (rst) begin
      qubits_reg = 4'd8;
      clear_vector();
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        qubits_reg = cfg_data;
        clear_vector();
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (measured_state !== exp_r.meas) begin
            $display("%0t: measured_state expected %0d actual %0d", $time, exp_r.meas,
                     measured_state);
            fail_count++;
          end
          if (amp_real !== exp_r.re) begin
            $display("%0t: amp_real expected %0d actual %0d", $time, exp_r.re, amp_real);
            fail_count++;
          end
          if (amp_imag !== exp_r.im) begin
            $display("%0t: amp_imag expected %0d actual %0d", $time, exp_r.im, amp_imag);
            fail_count++;
          end
          if (bad_qubit !== exp_r.bad) begin
            $display("%0t: bad_qubit expected %0b actual %0b", $time, exp_r.bad, bad_qubit);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_gate(got);
        result_q.push_back(got);
      end
    end
  end

endmodule

### tb/qubit_state_vector_gate_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qubit_state_vector_gate_engine_core_tb
// Drives directed and random gate sequences through several qubit counts,
// with random idling on both channels and one long receiver hold-off; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module qubit_state_vector_gate_engine_core_tb;
  import qsv_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_write = 0;
  logic [3:0]         cfg_data = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [3:0]         op = 0;
  logic [3:0]         target_qubit = 0;
  logic [3:0]         first_control = 0;
  logic [3:0]         second_control = 0;
  logic signed [15:0] angle_cos = 0;
  logic signed [15:0] angle_sin = 0;
  logic [9:0]         state_index = 0;
  logic [15:0]        random_value = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [9:0]         measured_state;
  logic signed [15:0] amp_real;
  logic signed [15:0] amp_imag;
  logic               bad_qubit;
  int                 fail_count;
  int                 pending;
  int                 sent_ops = 0;
  int                 out_beats = 0;
  int                 quiet_cycles = 0;
  int                 hold_left = 0;
  bit                 hold_done = 0;
  int                 active_qubits = 8;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  qubit_state_vector_gate_engine_core dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .target_qubit(target_qubit),
    .first_control(first_control), .second_control(second_control),
    .angle_cos(angle_cos), .angle_sin(angle_sin), .state_index(state_index),
    .random_value(random_value), .out_valid(out_valid), .out_ready(out_ready),
    .measured_state(measured_state), .amp_real(amp_real), .amp_imag(amp_imag),
    .bad_qubit(bad_qubit)
  );

  qubit_state_vector_gate_engine_core_chk chk (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .target_qubit(target_qubit),
    .first_control(first_control), .second_control(second_control),
    .angle_cos(angle_cos), .angle_sin(angle_sin), .state_index(state_index),
    .random_value(random_value), .out_valid(out_valid), .out_ready(out_ready),
    .measured_state(measured_state), .amp_real(amp_real), .amp_imag(amp_imag),
    .bad_qubit(bad_qubit), .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stalls, a quiet stretch, one long hold-off
  always @(posedge clk) begin
    if (out_valid && out_ready) out_beats <= out_beats + 1;
    if (rst) begin
      out_ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 0;
    end else if (!hold_done && out_beats == 60) begin
      hold_done <= 1;
      hold_left <= 3000;
      out_ready <= 0;
    end else if (out_beats >= 120 && out_beats < 170) begin
      out_ready <= 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 31);
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("qubit_state_vector_gate_engine_core verification failed");
        $finish;
      end
    end
  end

  task automatic send_gate(input op_t code, input logic [3:0] t, input logic [3:0] c1,
                           input logic [3:0] c2, input logic [15:0] c, input logic [15:0] s,
                           input logic [9:0] idx, input logic [15:0] rv);
    bit quiet;
    quiet = (sent_ops >= 130 && sent_ops < 180);
    if (!quiet && $urandom_range(0, 99) < 31) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    op <= code;
    target_qubit <= t;
    first_control <= c1;
    second_control <= c2;
    angle_cos <= c;
    angle_sin <= s;
    state_index <= idx;
    random_value <= rv;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sent_ops++;
  endtask

  task automatic set_qubits(input logic [3:0] count);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    cfg_data <= count;
    cfg_write <= 1;
    @(posedge clk);
    cfg_write <= 0;
    active_qubits = (count < 1) ? 1 : (count > 10) ? 10 : count;
  endtask

  function automatic logic [3:0] pick_qubit();
    if ($urandom_range(0, 99) < 88) return 4'($urandom_range(0, active_qubits - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic send_random();
    op_t code;
    logic [3:0] t, c1, c2;
    logic [9:0] idx;
    code = op_t'(4'($urandom_range(0, 15)));
    if (code == OP_MEASURE && active_qubits > 8 && $urandom_range(0, 1)) code = OP_READ;
    t = pick_qubit();
    c1 = pick_qubit();
    c2 = pick_qubit();
    if ($urandom_range(0, 3) == 0) idx = 10'($urandom_range(0, 1023));
    else idx = 10'($urandom_range(0, (1 << active_qubits) - 1));
    send_gate(code, t, c1, c2, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              idx, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    logic [3:0] phase_count [9] = '{4'd2, 4'd1, 4'd3, 4'd10, 4'd4, 4'd0, 4'd15, 4'd6, 4'd5};
    int         phase_items [9] = '{40, 25, 60, 10, 50, 20, 6, 40, 40};
    repeat (4) @(posedge clk);
    rst <= 0;
    send_gate(OP_READ, 0, 0, 0, 0, 0, 0, 0);
    send_gate(OP_H, 0, 0, 0, 0, 0, 0, 0);
    send_gate(OP_X, 7, 0, 0, 0, 0, 0, 0);
    send_gate(OP_Y, 1, 0, 0, 0, 0, 0, 0);
    send_gate(OP_Z, 0, 0, 0, 0, 0, 0, 0);
    send_gate(OP_CNOT, 1, 0, 0, 0, 0, 0, 0);
    send_gate(OP_TOFFOLI, 2, 0, 1, 0, 0, 0, 0);
    send_gate(OP_RX, 3, 0, 0, 16'sd23170, 16'sd23170, 0, 0);
    send_gate(OP_RY, 0, 0, 0, 16'sd32767, -16'sd32768, 0, 0);
    send_gate(OP_RZ, 4, 0, 0, 16'sd28378, -16'sd16384, 0, 0);
    send_gate(OP_CPHASE, 1, 1, 0, 16'sd0, 16'sd32767, 0, 0);
    send_gate(OP_ORACLE, 0, 0, 0, 0, 0, 10'd5, 0);
    send_gate(OP_ORACLE, 0, 0, 0, 0, 0, 10'd1023, 0);
    send_gate(OP_DIFFUSE, 0, 0, 0, 0, 0, 0, 0);
    send_gate(OP_MEASURE, 0, 0, 0, 0, 0, 0, 16'd0);
    send_gate(OP_MEASURE, 0, 0, 0, 0, 0, 0, 16'hFFFF);
    send_gate(OP_READ, 0, 0, 0, 0, 0, 10'd1023, 0);
    send_gate(OP_H, 8, 0, 0, 0, 0, 0, 0);
    send_gate(OP_TOFFOLI, 0, 1, 15, 0, 0, 0, 0);
    send_gate(OP_CNOT, 0, 9, 0, 0, 0, 0, 0);
    send_gate(op_t'(4'd15), 15, 15, 15, 16'hFFFF, 16'hFFFF, 10'h3FF, 16'hFFFF);
    send_gate(OP_INIT, 0, 0, 0, 0, 0, 0, 0);
    send_gate(OP_RY, 0, 0, 0, -16'sd32768, 16'sd0, 0, 0);
    send_gate(OP_ORACLE, 0, 0, 0, 0, 0, 10'd0, 0);
    send_gate(OP_RY, 1, 0, 0, 16'sd0, 16'sd0, 0, 0);
    send_gate(OP_MEASURE, 0, 0, 0, 0, 0, 0, 16'd40000);
    for (int ph = 0; ph < 9; ph++) begin
      set_qubits(phase_count[ph]);
      for (int k = 0; k < phase_items[ph]; k++) send_random();
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("qubit_state_vector_gate_engine_core verification clean");
    end else begin
      $display("qubit_state_vector_gate_engine_core verification failed");
    end
    $finish;
  end

endmodule
